>>> hdl/tts_pkg.sv
// Shared constants, token types and helpers for the text token scanner.
package tts_pkg;

  localparam int OFFSET_BITS = 16;
  localparam int OUT_W       = 16;
  localparam int MAX_TOK     = 3;
  localparam int TOK_CNT_W   = $clog2(MAX_TOK + 1);
  localparam int FIFO_DEPTH  = 4;
  localparam int IN_DATA_W   = 8;
  localparam int OUT_DATA_W  = 40;
  localparam int OUT_USER_W  = 2;

  localparam logic [1:0] KIND_WORD   = 2'd0;
  localparam logic [1:0] KIND_STRING = 2'd1;
  localparam logic [1:0] KIND_PUNCT  = 2'd2;
  localparam logic [1:0] KIND_END    = 2'd3;

  typedef struct packed {
    logic [1:0]       kind;
    logic [OUT_W-1:0] start;
    logic [OUT_W-1:0] length;
    logic             unterm;
    logic             ovf;
    logic             last;
  } tok_t;

  // All tokens raised by one input beat, in emission order.
  typedef struct packed {
    tok_t [MAX_TOK-1:0]   slot;
    logic [TOK_CNT_W-1:0] cnt;
  } bundle_t;

  // Offsets and lengths are reported modulo 2^OUT_W.
  function automatic logic [OUT_W-1:0] off_fit(input logic [OFFSET_BITS:0] v);
    logic [OFFSET_BITS+OUT_W:0] t;
    t = {{OUT_W{1'b0}}, v};
    return t[OUT_W-1:0];
  endfunction

endpackage

>>> hdl/text_token_scanner.sv
// Top level of the text token scanner: stream ports, scanner and token queue.
// A token raised by a byte is registered in the token queue and offered on the master side from there.
// Throughput: one text byte per cycle unless the queue is full; each byte yields zero to three tokens.
// Output drains one token per cycle while the receiver is ready; a four-bundle queue stalls input when full.
// Reset (async, active low) returns the scanner to between-tokens at offset zero
// and empties the queue.
module text_token_scanner import tts_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,   // [7:0] text_byte
  input  logic                  s_axis_tlast_i,   // end_of_text
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,   // token_start, token_length,
                                                  // unterminated, offset_overflow
  output logic [OUT_USER_W-1:0] m_axis_tuser_o,   // token_kind
  output logic                  m_axis_tlast_o    // last
);

  logic    accept, push;
  bundle_t bundle;
  tok_t    tok;

  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  tts_scan u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (s_axis_tdata_i),
    .eot_i    (s_axis_tlast_i),
    .push_o   (push),
    .bundle_o (bundle)
  );

  tts_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .bundle_i (bundle),
    .ready_o  (s_axis_tready_o),
    .valid_o  (m_axis_tvalid_o),
    .pop_i    (m_axis_tready_i),
    .tok_o    (tok)
  );

  assign m_axis_tdata_o = {6'b0, tok.ovf, tok.unterm, tok.length, tok.start};
  assign m_axis_tuser_o = tok.kind;
  assign m_axis_tlast_o = tok.last;

endmodule

>>> hdl/tts_scan.sv
// Scanner state and per-byte token decision logic.
module tts_scan import tts_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   accept_i,
  input  logic [IN_DATA_W-1:0]   byte_i,
  input  logic                   eot_i,
  output logic                   push_o,
  output bundle_t                bundle_o
);

  typedef enum logic [2:0] {
    M_IDLE, M_COMMENT, M_WORD, M_STR, M_ESC, M_HEX2, M_HEX1
  } mode_e;

  localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_XLO   = 8'h78;
  localparam logic [7:0] CH_XUP   = 8'h58;

  mode_e                  mode_q, mode_d;
  logic [OFFSET_BITS-1:0] pos_q, pos_d;
  logic [OFFSET_BITS-1:0] start_q, start_d;
  logic                   ovf_q, ovf_d;

  logic                   word_b, blank_b, at_max, ovf_n, run_idle, finish;
  logic [OFFSET_BITS-1:0] end_off, flush_start;
  mode_e                  flush_mode;
  logic [4:0]             cv;
  tok_t [4:0]             ct;
  tok_t [MAX_TOK-1:0]     slot;
  logic [TOK_CNT_W-1:0]   cnt;

  always_comb begin
    word_b  = (byte_i >= 8'h30 && byte_i <= 8'h39) || (byte_i >= 8'h41 && byte_i <= 8'h5A) ||
              (byte_i >= 8'h61 && byte_i <= 8'h7A) || byte_i == CH_DOT || byte_i == CH_UNDER;
    blank_b = byte_i == CH_SP || byte_i == CH_TAB || byte_i == CH_LF || byte_i == CH_CR;
    at_max  = pos_q == POS_MAX;
    ovf_n   = ovf_q | ((byte_i != CH_NUL) & at_max);
    mode_d  = mode_q;
    start_d = start_q;
    pos_d   = pos_q;
    ovf_d   = ovf_n;
    run_idle = 1'b0;
    cv = '0;
    for (int i = 0; i < 5; i++) begin
      ct[i] = '{kind: KIND_END, start: '0, length: '0, unterm: 1'b0, ovf: ovf_n, last: 1'b0};
    end

    if (byte_i != CH_NUL) begin
      case (mode_q)
        M_WORD: begin
          if (!word_b) begin
            cv[0]        = 1'b1;
            ct[0].kind   = KIND_WORD;
            ct[0].start  = off_fit({1'b0, start_q});
            ct[0].length = off_fit({1'b0, pos_q} - {1'b0, start_q});
            mode_d       = M_IDLE;
            run_idle     = 1'b1;
          end
        end
        M_COMMENT: begin
          if (byte_i == CH_LF) mode_d = M_IDLE;
        end
        M_STR: begin
          if (byte_i == CH_BSL) begin
            mode_d = M_ESC;
          end else if (byte_i == CH_QUOTE) begin
            cv[2]        = 1'b1;
            ct[2].kind   = KIND_STRING;
            ct[2].start  = off_fit({1'b0, start_q});
            ct[2].length = off_fit({1'b0, pos_q} - {1'b0, start_q} + 1'b1);
            mode_d       = M_IDLE;
          end
        end
        M_ESC:  mode_d = (byte_i == CH_XLO || byte_i == CH_XUP) ? M_HEX2 : M_STR;
        M_HEX2: mode_d = M_HEX1;
        M_HEX1: mode_d = M_STR;
        default: begin
          mode_d   = M_IDLE;
          run_idle = 1'b1;
        end
      endcase
      if (run_idle && !blank_b) begin
        if (byte_i == CH_HASH) begin
          mode_d = M_COMMENT;
        end else if (byte_i == CH_QUOTE) begin
          mode_d  = M_STR;
          start_d = pos_q;
        end else if (word_b) begin
          mode_d  = M_WORD;
          start_d = pos_q;
        end else begin
          cv[1]        = 1'b1;
          ct[1].kind   = KIND_PUNCT;
          ct[1].start  = off_fit({1'b0, pos_q});
          ct[1].length = off_fit({{OFFSET_BITS{1'b0}}, 1'b1});
        end
      end
      end_off     = at_max ? pos_q : pos_q + 1'b1;
      finish      = eot_i;
      flush_mode  = mode_d;
      flush_start = start_d;
    end else begin
      end_off     = pos_q;
      finish      = 1'b1;
      flush_mode  = mode_q;
      flush_start = start_q;
    end

    if (finish) begin
      if (flush_mode == M_WORD) begin
        cv[3]      = 1'b1;
        ct[3].kind = KIND_WORD;
      end else if (flush_mode == M_STR || flush_mode == M_ESC ||
                   flush_mode == M_HEX2 || flush_mode == M_HEX1) begin
        cv[3]        = 1'b1;
        ct[3].kind   = KIND_STRING;
        ct[3].unterm = 1'b1;
      end
      ct[3].start  = off_fit({1'b0, flush_start});
      ct[3].length = off_fit({1'b0, end_off} - {1'b0, flush_start});
      cv[4]        = 1'b1;
      ct[4].kind   = KIND_END;
      ct[4].start  = off_fit({1'b0, end_off});
      ct[4].last   = 1'b1;
      mode_d  = M_IDLE;
      pos_d   = '0;
      start_d = '0;
      ovf_d   = 1'b0;
    end else begin
      pos_d = end_off;
    end

    // pack the candidates in order into the bundle
    slot = '0;
    cnt  = '0;
    for (int i = 0; i < 5; i++) begin
      if (cv[i] && cnt != TOK_CNT_W'(MAX_TOK)) begin
        slot[cnt] = ct[i];
        cnt       = cnt + 1'b1;
      end
    end
  end

  assign bundle_o = {slot, cnt};
  assign push_o   = accept_i && cnt != '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= M_IDLE;
      pos_q   <= '0;
      start_q <= '0;
      ovf_q   <= 1'b0;
    end else if (accept_i) begin
      mode_q  <= mode_d;
      pos_q   <= pos_d;
      start_q <= start_d;
      ovf_q   <= ovf_d;
    end
  end

  a_zero_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && byte_i == CH_NUL |-> push_o && bundle_o.slot[cnt - 1'b1].last)
    else $error("zero byte did not close the text");

  a_clear_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && (eot_i || byte_i == CH_NUL) |=> pos_q == '0 && mode_q == M_IDLE && !ovf_q)
    else $error("state not cleared after end of text");

  a_start_le_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_q <= pos_q)
    else $error("token start beyond position");

endmodule

>>> hdl/tts_queue.sv
// Queue of token bundles, drained one token per output beat.
module tts_queue import tts_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  bundle_t bundle_i,
  output logic    ready_o,
  output logic    valid_o,
  input  logic    pop_i,
  output tok_t    tok_o
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int LVL_W = $clog2(FIFO_DEPTH + 1);

  bundle_t              mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0]     wr_ptr_q, rd_ptr_q;
  logic [LVL_W-1:0]     level_q, level_d;
  logic [TOK_CNT_W-1:0] sub_q;
  bundle_t              head;
  logic                 beat, done;

  assign head    = mem_q[rd_ptr_q];
  assign valid_o = level_q != '0;
  assign ready_o = level_q != LVL_W'(FIFO_DEPTH);
  assign tok_o   = head.slot[sub_q];
  assign beat    = valid_o && pop_i;
  assign done    = beat && sub_q == head.cnt - 1'b1;

  always_comb begin
    level_d = level_q;
    case ({push_i, done})
      2'b10:   level_d = level_q + 1'b1;
      2'b01:   level_d = level_q - 1'b1;
      default: level_d = level_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= bundle_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
      sub_q    <= '0;
    end else begin
      level_q <= level_d;
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (done) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
        sub_q    <= '0;
      end else if (beat) begin
        sub_q <= sub_q + 1'b1;
      end
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> ready_o)
    else $error("push into full queue");

  a_head_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> head.cnt != '0 && sub_q < head.cnt)
    else $error("head bundle index out of range");

  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_q <= LVL_W'(FIFO_DEPTH))
    else $error("queue level beyond depth");

endmodule

>>> dv/tts_checker.sv
// Token predictor and scoreboard for the text token scanner streams.
module tts_checker import tts_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_tvalid_i,
  input  logic                  s_tready_i,
  input  logic [IN_DATA_W-1:0]  s_tdata_i,   // [7:0] text_byte
  input  logic                  s_tlast_i,   // end_of_text
  input  logic                  m_tvalid_i,
  input  logic                  m_tready_i,
  input  logic [OUT_DATA_W-1:0] m_tdata_i,   // token_start, token_length,
                                             // unterminated, offset_overflow
  input  logic [OUT_USER_W-1:0] m_tuser_i,   // token_kind
  input  logic                  m_tlast_i,   // last
  output int                    fail_cnt_o,
  output int                    pending_o,
  output int                    tok_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    SC_IDLE, SC_COMMENT, SC_WORD, SC_STR, SC_ESC, SC_HEX2, SC_HEX1
  } scan_e;

  localparam longint unsigned POS_MAX = (64'd1 << OFFSET_BITS) - 64'd1;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_X_UP   = 8'h58;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_X_LO   = 8'h78;

  scan_e            mode;
  longint unsigned  next_off;
  longint unsigned  tok_start;
  logic             ovf_seen;
  tok_t             exp_toks[$];
  tok_t             want;

  function automatic logic is_blank(input logic [7:0] b);
    return b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_CR;
  endfunction

  function automatic logic is_word_char(input logic [7:0] b);
    return (b >= "0" && b <= "9") || (b >= "A" && b <= "Z") ||
           (b >= "a" && b <= "z") || b == "." || b == "_";
  endfunction

  task automatic expect_token(input logic [1:0] kind, input longint unsigned start,
                              input longint unsigned len, input logic unterm,
                              input logic last);
    tok_t t;
    t.kind   = kind;
    t.start  = start[OUT_W-1:0];
    t.length = len[OUT_W-1:0];
    t.unterm = unterm;
    t.ovf    = ovf_seen;
    t.last   = last;
    exp_toks.push_back(t);
  endtask

  task automatic end_text(input longint unsigned end_off);
    if (mode == SC_WORD) begin
      expect_token(KIND_WORD, tok_start, end_off - tok_start, 1'b0, 1'b0);
    end else if (mode == SC_STR || mode == SC_ESC || mode == SC_HEX2 || mode == SC_HEX1) begin
      expect_token(KIND_STRING, tok_start, end_off - tok_start, 1'b1, 1'b0);
    end
    expect_token(KIND_END, end_off, 0, 1'b0, 1'b1);
    mode      = SC_IDLE;
    next_off  = 0;
    tok_start = 0;
    ovf_seen  = 1'b0;
  endtask

  task automatic begin_token(input logic [7:0] b, input longint unsigned pos);
    if (is_blank(b)) begin
      mode = SC_IDLE;
    end else if (b == CH_HASH) begin
      mode = SC_COMMENT;
    end else if (b == CH_QUOTE) begin
      mode      = SC_STR;
      tok_start = pos;
    end else if (is_word_char(b)) begin
      mode      = SC_WORD;
      tok_start = pos;
    end else begin
      expect_token(KIND_PUNCT, pos, 1, 1'b0, 1'b0);
    end
  endtask

  task automatic scan_byte(input logic [7:0] b, input logic eot);
    longint unsigned pos;
    pos = next_off;
    if (b == CH_NUL) begin
      end_text(pos);
    end else begin
      if (pos >= POS_MAX) begin
        pos      = POS_MAX;
        ovf_seen = 1'b1;
      end
      case (mode)
        SC_WORD: begin
          if (!is_word_char(b)) begin
            expect_token(KIND_WORD, tok_start, pos - tok_start, 1'b0, 1'b0);
            mode = SC_IDLE;
            begin_token(b, pos);
          end
        end
        SC_COMMENT: begin
          if (b == CH_LF) mode = SC_IDLE;
        end
        SC_STR: begin
          if (b == CH_BSLASH) begin
            mode = SC_ESC;
          end else if (b == CH_QUOTE) begin
            expect_token(KIND_STRING, tok_start, pos - tok_start + 1, 1'b0, 1'b0);
            mode = SC_IDLE;
          end
        end
        SC_ESC: begin
          mode = (b == CH_X_LO || b == CH_X_UP) ? SC_HEX2 : SC_STR;
        end
        SC_HEX2: begin
          mode = SC_HEX1;
        end
        SC_HEX1: begin
          mode = SC_STR;
        end
        default: begin
          mode = SC_IDLE;
          begin_token(b, pos);
        end
      endcase
      if (eot) begin
        end_text(pos >= POS_MAX ? POS_MAX : pos + 1);
      end else begin
        next_off = (pos >= POS_MAX) ? POS_MAX : pos + 1;
      end
    end
  endtask

  task automatic field_cmp(input string name, input logic [15:0] exp_v,
                           input logic [15:0] act_v);
    if (exp_v !== act_v) begin
      fail_cnt_o++;
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode       = SC_IDLE;
      next_off   = 0;
      tok_start  = 0;
      ovf_seen   = 1'b0;
      exp_toks.delete();
      fail_cnt_o = 0;
      pending_o  = 0;
      tok_seen_o = 0;
    end else begin
      if (s_tvalid_i && s_tready_i) scan_byte(s_tdata_i[7:0], s_tlast_i);
      if (m_tvalid_i && m_tready_i) begin
        tok_seen_o++;
        if (exp_toks.size() == 0) begin
          fail_cnt_o++;
          $display("%0t: token with none expected, expected nothing, got kind %0d start %0d len %0d",
                   $time, m_tuser_i, m_tdata_i[15:0], m_tdata_i[31:16]);
        end else begin
          want = exp_toks.pop_front();
          field_cmp("kind", 16'(want.kind), 16'(m_tuser_i));
          field_cmp("start", want.start, m_tdata_i[15:0]);
          field_cmp("length", want.length, m_tdata_i[31:16]);
          field_cmp("unterminated", 16'(want.unterm), 16'(m_tdata_i[32]));
          field_cmp("overflow", 16'(want.ovf), 16'(m_tdata_i[33]));
          field_cmp("last", 16'(want.last), 16'(m_tlast_i));
        end
      end
      pending_o = exp_toks.size();
    end
  end

endmodule

>>> dv/tb.sv
// Stimulus, flow control and verdict for the text token scanner testbench.
module tb import tts_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] END_BYTE   = 8'h00;
  localparam int         LONG_STALL = 80;
  localparam string WORD_SET  = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789._";
  localparam string PUNCT_SET = "!$%&'()*+,-/:;<=>?@[\\]^`{|}~";
  localparam string BLANK_SET = " \t\r\n";

  logic                  clk_i    = 1'b0;
  logic                  rst_ni   = 1'b0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata  = '0;
  logic                  s_tlast  = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [OUT_USER_W-1:0] m_tuser;
  logic                  m_tlast;

  int         fail_cnt;
  int         pending;
  int         tok_seen;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  int         bytes_sent    = 0;
  int         texts_sent    = 0;
  bit         long_stall_req = 1'b0;
  logic [7:0] text_q[$];

  always #5 clk_i = ~clk_i;

  text_token_scanner dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  tts_checker chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid),
    .s_tready_i (s_tready),
    .s_tdata_i  (s_tdata),
    .s_tlast_i  (s_tlast),
    .m_tvalid_i (m_tvalid),
    .m_tready_i (m_tready),
    .m_tdata_i  (m_tdata),
    .m_tuser_i  (m_tuser),
    .m_tlast_i  (m_tlast),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending),
    .tok_seen_o (tok_seen)
  );

  // receiver back-pressure, with an occasional long hold-off
  initial forever begin
    @(negedge clk_i);
    if (long_stall_req) begin
      long_stall_req = 1'b0;
      m_tready <= 1'b0;
      repeat (LONG_STALL) @(negedge clk_i);
    end
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // called at a falling edge; returns at the falling edge after the beat
  task automatic push_byte(input logic [7:0] b, input logic eot);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= eot;
    do @(posedge clk_i); while (s_tready !== 1'b1);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_text(input string s, input logic eot_last);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], eot_last && (i == s.len() - 1));
  endtask

  function automatic logic [7:0] pick(input string set);
    return set[$urandom_range(set.len() - 1)];
  endfunction

  task automatic build_token();
    logic [7:0] b;
    case ($urandom_range(9))
      0, 1, 2, 3: begin
        repeat ($urandom_range(1, 6)) text_q.push_back(pick(WORD_SET));
      end
      4, 5: begin
        text_q.push_back("\"");
        repeat ($urandom_range(5)) begin
          case ($urandom_range(5))
            0: begin
              text_q.push_back("\\");
              text_q.push_back(8'($urandom_range(255)));
            end
            1: begin
              text_q.push_back("\\");
              text_q.push_back($urandom_range(1) ? "x" : "X");
              text_q.push_back(8'($urandom_range(1, 255)));
              text_q.push_back(8'($urandom_range(1, 255)));
            end
            default: begin
              b = 8'($urandom_range(1, 255));
              if (b == "\"" || b == "\\") b = "s";
              text_q.push_back(b);
            end
          endcase
        end
        if ($urandom_range(9) != 0) text_q.push_back("\"");
      end
      6: begin
        case ($urandom_range(3))
          0:       text_q.push_back(8'($urandom_range(8'h80, 8'hFF)));
          1:       text_q.push_back(8'($urandom_range(1, 8)));
          2:       text_q.push_back("\\");
          default: text_q.push_back(pick(PUNCT_SET));
        endcase
      end
      7: begin
        text_q.push_back("#");
        repeat ($urandom_range(4)) begin
          b = 8'($urandom_range(1, 255));
          if (b == "\n") b = "#";
          text_q.push_back(b);
        end
        if ($urandom_range(9) != 0) text_q.push_back("\n");
      end
      8: begin
        repeat ($urandom_range(1, 3)) text_q.push_back(pick(BLANK_SET));
      end
      default: begin
        text_q.push_back(8'($urandom_range(255)));
      end
    endcase
  endtask

  // a run of tokens with random content, usually ended by flag or zero
  task automatic send_random_text();
    int   r;
    logic zero_end;
    logic flag_end;
    text_q.delete();
    repeat ($urandom_range(1, 8)) build_token();
    r        = $urandom_range(9);
    zero_end = (r < 3);
    flag_end = (r >= 3 && r < 9);
    if (zero_end) text_q.push_back(END_BYTE);
    foreach (text_q[i]) begin
      push_byte(text_q[i], (i == text_q.size() - 1) &&
                           (flag_end || (zero_end && $urandom_range(1) == 1)));
    end
    texts_sent++;
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_idle_pct = 38;
    recv_idle_pct = 46;
    send_text("ab#c\n", 1'b0);            // comment straight after a word
    send_text("\"q\\\"\\x41\"", 1'b0);    // escaped quote and hex escape
    push_byte(8'hFF, 1'b0);
    send_text("\\", 1'b0);                // backslash outside a string
    send_text("w;", 1'b1);                // word, punctuation and end in one beat
    send_text("\"\\x", 1'b0);             // open string with escape pending...
    push_byte(END_BYTE, 1'b0);            // ...closed by a zero byte
    send_text("#z", 1'b1);                // comment open at end of text
    send_text("k", 1'b0);
    push_byte(END_BYTE, 1'b1);
    while (bytes_sent < 100) send_random_text();
    settle();

    send_idle_pct = 46;
    recv_idle_pct = 38;
    long_stall_req = 1'b1;
    repeat (30) push_byte(pick(PUNCT_SET), 1'b0);
    push_byte(";", 1'b1);
    settle();
    while (bytes_sent < 180) send_random_text();
    settle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (bytes_sent < 250) send_random_text();
    settle();

    $display("Scanned %0d bytes: directed cases, %0d random texts and a long back-pressure",
             bytes_sent, texts_sent);
    $display("burst that filled the queue; %0d tokens compared, %0d mismatches.",
             tok_seen, fail_cnt);
    if (fail_cnt == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timed out with %0d tokens outstanding.", pending);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
